/* hw/rtl/ant_pkg.sv */
// ----------------------------------------------------------------------------
// ant_pkg
// Shared constants, payload structs and result codes of the aging node table.
// ----------------------------------------------------------------------------
package ant_pkg;

    localparam int TABLE_DEPTH      = 64;
    localparam int IDX_W            = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);

    localparam int TIMEOUT_SECONDS  = (3 * 60);
    localparam int TICKS_PER_SECOND = 128;
    localparam logic [31:0] TIMEOUT_RESET = 32'(TIMEOUT_SECONDS * TICKS_PER_SECOND);

    localparam int RSP_CNT_W        = 7;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_SWEPT    = 2'd3;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_SWEEP  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] node_id;
        logic [15:0] uplink_id;
        logic [31:0] now_time;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [RSP_CNT_W-1:0] entry_count;
        logic [RSP_CNT_W-1:0] removed_count;
    } t_rsp;

    typedef struct packed {
        logic [15:0] node_id;
        logic [15:0] uplink_id;
        logic [31:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic hit;
        logic expired;
    } t_cmp;

endpackage

/* hw/rtl/ant_ram.sv */
// ----------------------------------------------------------------------------
// ant_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ant_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ant_unit.sv */
// ----------------------------------------------------------------------------
// ant_unit
// Shared compare unit: node id match and wrapping age against the timeout.
// ----------------------------------------------------------------------------
module ant_unit (
    input  ant_pkg::t_entry i_entry,
    input  logic [15:0]     i_key,
    input  logic [31:0]     i_now,
    input  logic [31:0]     i_timeout,
    output ant_pkg::t_cmp   o_cmp
);
    import ant_pkg::*;

    logic [31:0] age;

    // age wraps modulo 2^32
    assign age           = i_now - i_entry.stamp;
    assign o_cmp.hit     = (i_entry.node_id == i_key);
    assign o_cmp.expired = (age >= i_timeout);

endmodule

/* hw/rtl/aging_node_table.sv */
// ----------------------------------------------------------------------------
// aging_node_table
// Learning table of node id, parent id and last report time, with aging.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result beat, which o_done marks for one cycle and which cannot be
// held off. Entries live in one RAM that is read one entry per cycle through
// its single registered read port; a report stops at its first hit, and a
// sweep reads every entry below the entry count. The RAM needs no clearing
// pass: only entries below the entry count are ever read.
// r_timeout resets to 23040.
module aging_node_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ant_pkg::t_req i_req,
    output logic          o_done,
    output ant_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data
);
    import ant_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             r_chk_vld, n_chk_vld;
    logic [31:0]      r_timeout;
    t_req             r_req, n_req;
    logic             r_done, n_done;
    t_rsp             r_rsp, n_rsp;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;
    t_entry             new_entry;
    t_cmp               cmp;
    logic               issue;

    ant_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    ant_unit u_unit (
        .i_entry   (rd_entry),
        .i_key     (r_req.node_id),
        .i_now     (r_req.now_time),
        .i_timeout (r_timeout),
        .o_cmp     (cmp)
    );

    assign new_entry.node_id   = r_req.node_id;
    assign new_entry.uplink_id = r_req.uplink_id;
    assign new_entry.stamp     = r_req.now_time;

    assign issue = (r_rd_idx < r_count);
    assign busy  = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_wr      = r_wr;
        n_chk_idx = r_chk_idx;
        n_chk_vld = r_chk_vld;
        n_req     = r_req;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = new_entry;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_rd_idx  = '0;
                    n_wr      = '0;
                    n_chk_vld = 1'b0;
                    n_state   = (i_req.req_type == REQ_SWEEP) ? S_SWEEP : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_chk_vld && cmp.hit) begin
                    // refresh parent and stamp in place
                    ram_we                = 1'b1;
                    n_done                = 1'b1;
                    n_rsp.status          = ST_UPDATED;
                    n_rsp.entry_count     = RSP_CNT_W'(r_count);
                    n_rsp.removed_count   = '0;
                    n_state               = S_IDLE;
                end else if (!r_chk_vld && !issue) begin
                    n_done              = 1'b1;
                    n_rsp.removed_count = '0;
                    n_state             = S_IDLE;
                    if (r_count < CNT_W'(TABLE_DEPTH)) begin
                        ram_we            = 1'b1;
                        ram_waddr         = r_count[IDX_W-1:0];
                        n_count           = r_count + 1'b1;
                        n_rsp.status      = ST_INSERTED;
                        n_rsp.entry_count = RSP_CNT_W'(r_count + 1'b1);
                    end else begin
                        n_rsp.status      = ST_DROPPED;
                        n_rsp.entry_count = RSP_CNT_W'(r_count);
                    end
                end else begin
                    n_chk_vld = issue;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                    if (issue) begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            S_SWEEP: begin
                if (r_chk_vld && !cmp.expired) begin
                    // keep entry: move it down to the compacted end
                    ram_we    = 1'b1;
                    ram_waddr = r_wr[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                    n_wr      = r_wr + 1'b1;
                end
                if (!r_chk_vld && !issue) begin
                    n_count             = r_wr;
                    n_done              = 1'b1;
                    n_rsp.status        = ST_SWEPT;
                    n_rsp.entry_count   = RSP_CNT_W'(r_wr);
                    n_rsp.removed_count = RSP_CNT_W'(r_count - r_wr);
                    n_state             = S_IDLE;
                end else begin
                    n_chk_vld = issue;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                    if (issue) begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            r_done    <= n_done;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_wr      <= n_wr;
        r_chk_idx <= n_chk_idx;
        r_req     <= n_req;
        r_rsp     <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a preceding busy item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_report_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != ST_SWEPT) |-> (o_rsp.removed_count == '0))
        else $error("report beat with nonzero removed count");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_chk_vld) |-> (r_wr <= CNT_W'(r_chk_idx)))
        else $error("compaction write index ahead of read index");

endmodule

/* tb/aging_node_table_test.sv */
// ----------------------------------------------------------------------------
// aging_node_table_test
// Self-checking bench for the aging node table. Reports and sweeps go in over
// the start/busy handshake; a scoreboard keeps its own copy of the table and
// the timeout and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module aging_node_table_test;

    import ant_pkg::*;

    class node_table_checker;
        logic [15:0]  node_ids   [TABLE_DEPTH];
        logic [15:0]  uplink_ids [TABLE_DEPTH];
        logic [31:0]  stamps     [TABLE_DEPTH];
        int unsigned  live;
        logic [31:0]  timeout_ticks;
        t_rsp         awaited_rsp[$];
        int unsigned  failures;

        function new();
            live          = 0;
            timeout_ticks = TIMEOUT_RESET;
            failures      = 0;
        endfunction

        function void set_timeout(input logic [31:0] value);
            timeout_ticks = value;
        endfunction

        function int unsigned pending();
            return awaited_rsp.size();
        endfunction

        // Work out the result of one accepted beat and queue it.
        function void note_request(input t_req req);
            t_rsp        rsp;
            int unsigned k;
            int unsigned kept;
            bit          found;
            logic [31:0] age;
            rsp = '0;
            if (req.req_type == REQ_SWEEP) begin
                kept = 0;
                // Compact survivors toward the front, keeping their order.
                for (k = 0; k < live; k++) begin
                    age = req.now_time - stamps[k];
                    if (age < timeout_ticks) begin
                        node_ids[kept]   = node_ids[k];
                        uplink_ids[kept] = uplink_ids[k];
                        stamps[kept]     = stamps[k];
                        kept++;
                    end
                end
                rsp.status        = ST_SWEPT;
                rsp.removed_count = RSP_CNT_W'(live - kept);
                live              = kept;
            end else begin
                found = 1'b0;
                for (k = 0; k < live && !found; k++) begin
                    if (node_ids[k] == req.node_id) begin
                        uplink_ids[k] = req.uplink_id;
                        stamps[k]     = req.now_time;
                        found         = 1'b1;
                    end
                end
                if (found) begin
                    rsp.status = ST_UPDATED;
                end else if (live < TABLE_DEPTH) begin
                    node_ids[live]   = req.node_id;
                    uplink_ids[live] = req.uplink_id;
                    stamps[live]     = req.now_time;
                    live++;
                    rsp.status = ST_INSERTED;
                end else begin
                    rsp.status = ST_DROPPED;
                end
            end
            rsp.entry_count = RSP_CNT_W'(live);
            awaited_rsp.push_back(rsp);
        endfunction

        function void check_response(input t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected beat: status=%0d count=%0d removed=%0d",
                             got.status, got.entry_count, got.removed_count);
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status || got.entry_count !== want.entry_count ||
                got.removed_count !== want.removed_count) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: status %0d/%0d count %0d/%0d removed %0d/%0d (exp/got)",
                             want.status, got.status, want.entry_count, got.entry_count,
                             want.removed_count, got.removed_count);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_req        i_req      = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_we   = 1'b0;
    logic [31:0] i_cfg_data = '0;

    node_table_checker tracker = new();
    logic [31:0]       clock_ticks;

    aging_node_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Results cannot be held off: take every beat at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            tracker.check_response(o_rsp);
    end

    function automatic t_req make_req(input logic kind, input logic [15:0] nid,
                                      input logic [15:0] pid, input logic [31:0] now);
        t_req r;
        r.req_type  = kind;
        r.node_id   = nid;
        r.uplink_id = pid;
        r.now_time  = now;
        return r;
    endfunction

    // Called right after a rising edge; returns at the edge that takes the beat.
    // Start stays high so a back-to-back beat needs no extra edge.
    task automatic send_req(input t_req req);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(req);
    endtask

    task automatic hold_off(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0 || busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_timeout(value);
    endtask

    task automatic run_phase(input int unsigned n_items, input int unsigned id_pool,
                             input int unsigned sweep_pct, input bit with_gaps);
        t_req        req;
        logic [31:0] step_max;
        logic [15:0] id_base;
        int unsigned i;
        step_max = (tracker.timeout_ticks >> 2) + 32'd1;
        id_base  = 16'($urandom);
        for (i = 0; i < n_items; i++) begin
            req.req_type = ($urandom_range(99) < sweep_pct) ? REQ_SWEEP : REQ_REPORT;
            // Mostly a small id pool so entries get hit, filled and aged out.
            if ($urandom_range(9) == 0)
                req.node_id = 16'($urandom);
            else
                req.node_id = id_base + 16'($urandom_range(id_pool - 1));
            req.uplink_id = 16'($urandom);
            if ($urandom_range(49) == 0)
                clock_ticks = $urandom;
            else
                clock_ticks = clock_ticks + $urandom_range(step_max);
            req.now_time = clock_ticks;
            send_req(req);
            if (with_gaps && $urandom_range(99) < 13)
                hold_off($urandom_range(70, 1));
        end
        drain();
    endtask

    initial begin
        int unsigned p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timeout: wrapped ages, exact boundary, empty sweep.
        send_req(make_req(REQ_REPORT, 16'h0000, 16'hFFFF, 32'h0000_0000));
        send_req(make_req(REQ_REPORT, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF));
        send_req(make_req(REQ_REPORT, 16'h0000, 16'h1234, 32'd5));
        send_req(make_req(REQ_SWEEP, 16'hFFFF, 16'hFFFF, 32'd0));
        send_req(make_req(REQ_REPORT, 16'h8000, 16'hA5A5, 32'd100));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'd23139));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'd23140));
        send_req(make_req(REQ_SWEEP, 16'h5A5A, 16'h5A5A, 32'd23141));
        drain();

        write_timeout(32'd1);
        send_req(make_req(REQ_REPORT, 16'h0001, 16'h7FFF, 32'd7));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'd7));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'd8));
        drain();

        // Zero timeout drops everything on a sweep.
        write_timeout(32'd0);
        send_req(make_req(REQ_REPORT, 16'h0002, 16'h0003, 32'h8000_0000));
        send_req(make_req(REQ_REPORT, 16'h0004, 16'h0005, 32'h8000_0000));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'h8000_0000));
        drain();

        write_timeout(32'hFFFF_FFFF);
        send_req(make_req(REQ_REPORT, 16'h0006, 16'h0007, 32'h0000_0000));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'hFFFF_FFFE));
        send_req(make_req(REQ_SWEEP, 16'h0000, 16'h0000, 32'hFFFF_FFFF));
        drain();

        clock_ticks = $urandom;
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    // Timeout at its maximum: fill the table and overflow it.
                    run_phase(200, 90, 3, 1'b1);
                end
                1: begin
                    write_timeout(TIMEOUT_RESET);
                    run_phase(200, 40, 12, 1'b1);
                end
                2: begin
                    write_timeout(32'($urandom_range(50000, 1)));
                    run_phase(200, 70, 10, 1'b0);
                end
                3: begin
                    write_timeout(32'd1);
                    run_phase(200, 8, 15, 1'b1);
                end
                4: begin
                    write_timeout(32'd0);
                    run_phase(150, 70, 8, 1'b1);
                end
                5: begin
                    write_timeout($urandom);
                    run_phase(200, 100, 10, 1'b1);
                end
                6: begin
                    write_timeout(32'hFFFF_FFFF);
                    run_phase(200, 70, 15, 1'b1);
                end
                default: begin
                    write_timeout(32'($urandom_range(2000000, 100)));
                    run_phase(200, 64, 12, 1'b1);
                end
            endcase
        end

        repeat (80) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ant_pkg.sv
hw/rtl/ant_ram.sv
hw/rtl/ant_unit.sv
hw/rtl/aging_node_table.sv
tb/aging_node_table_test.sv
